[design/pgrav_pkg.sv]
// ---------------------------------------------------------------------------
// pgrav_pkg: shared widths, types and register codes
// Widths of the point-mass acceleration datapath and the sideband records
// that travel alongside the square-root and divider pipelines.
// ---------------------------------------------------------------------------
package pgrav_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int AXES          = 3;
	localparam int MAG_W         = DATA_W + 1;
	localparam int R2_W          = 2 * MAG_W;
	localparam int RT_W          = R2_W / 2;
	localparam int R2_CHUNK      = R2_W / 3;
	localparam int GM_W          = 2 * DATA_W;
	localparam int PROD_W        = GM_W + MAG_W;
	localparam int DEN_W         = R2_W + RT_W;
	localparam int QB            = 34;
	localparam int CFG_IDX_W     = 3;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRAV_CONST  = 3'd0,
		CFG_SOURCE_MASS = 3'd1,
		CFG_SOURCE_X    = 3'd2,
		CFG_SOURCE_Y    = 3'd3,
		CFG_SOURCE_Z    = 3'd4
	} cfg_idx_t;

	// Fields that ride alongside the divider
	typedef struct packed {
		logic                               ena;
		logic                               last;
		logic                               sing;
		logic [AXES-1:0]                    sgn;
		logic [AXES-1:0][DATA_W-1:0]        acc;
	} tail_t;

	// Fields that ride alongside the square root
	typedef struct packed {
		tail_t                              tail;
		logic [AXES-1:0][MAG_W-1:0]         mag;
		logic [GM_W-1:0]                    gm;
		logic [R2_W-1:0]                    r2;
	} mid_t;

endpackage

[design/point_mass_gravity_accel_unit.sv]
// ---------------------------------------------------------------------------
// point_mass_gravity_accel_unit: acceleration from a stationary point mass
// Adds -G*M*d/r^3 to each particle's running acceleration, in fixed point
// with FRAC_BITS fraction bits, saturating at the signed 32-bit range.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                       | tuser          | tlast
//  s_axis   | in  | pos_x pos_y pos_z acc_in_x acc_in_y acc_in_z | enabled     | last_in
//  m_axis   | out | acc_out_x acc_out_y acc_out_z            | singular, saturated | last_out
//  cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One particle per cycle enters while the output is not stalled; the path runs
// through the 33-stage square root, the 35-stage divider and eight arithmetic stages.
// Reset clears all stage valid bits and loads the register defaults.
// The whole pipeline holds when the output beat waits, so nothing is lost.
// ---------------------------------------------------------------------------
module point_mass_gravity_accel_unit #(
	parameter int FRAC_BITS = pgrav_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pgrav_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pgrav_pkg::DATA_W-1:0]         cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// pos_x, pos_y, pos_z, acc_in_x, acc_in_y, acc_in_z
	input  logic [6*pgrav_pkg::DATA_W-1:0]       s_axis_tdata,
	// enabled
	input  logic [0:0]                           s_axis_tuser,
	input  logic                                 s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// acc_out_x, acc_out_y, acc_out_z
	output logic [3*pgrav_pkg::DATA_W-1:0]       m_axis_tdata,
	// singular, saturated
	output logic [1:0]                           m_axis_tuser,
	output logic                                 m_axis_tlast
);

	localparam int DW     = pgrav_pkg::DATA_W;
	localparam int L      = pgrav_pkg::AXES;
	localparam int MW     = pgrav_pkg::MAG_W;
	localparam int R2W    = pgrav_pkg::R2_W;
	localparam int RTW    = pgrav_pkg::RT_W;
	localparam int CH     = pgrav_pkg::R2_CHUNK;
	localparam int GMW    = pgrav_pkg::GM_W;
	localparam int PW     = pgrav_pkg::PROD_W;
	localparam int DNW    = pgrav_pkg::DEN_W;
	localparam int QB     = pgrav_pkg::QB;
	localparam int NUM_W  = PW + FRAC_BITS;
	localparam int SW     = DW + 3;
	localparam int MID_W  = $bits(pgrav_pkg::mid_t);
	localparam int TAIL_W = $bits(pgrav_pkg::tail_t);
	localparam logic [QB-1:0] Q_CLAMP = QB'(1) << (QB - 1);

	// configuration registers
	logic [DW-1:0]        grav_q;
	logic [DW-1:0]        mass_q;
	logic [L-1:0][DW-1:0] src_q;

	logic en;

	// stage registers
	logic                        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic [L-1:0][MW-1:0]        d_s1;
	logic [L-1:0][DW-1:0]        acc_s1, acc_s2, acc_s3;
	logic                        ena_s1, ena_s2, ena_s3, last_s1, last_s2, last_s3;
	logic [GMW-1:0]              gm_s1, gm_s2, gm_s3;
	logic [L-1:0][MW-1:0]        mag_s2, mag_s3;
	logic [L-1:0]                sgn_s2, sgn_s3;
	logic [L-1:0][R2W-1:0]       sq_s3;
	logic                        sing_s3;
	logic [R2W-1:0]              r2_s4;
	pgrav_pkg::mid_t             mid_s4;
	logic [2:0][CH+RTW-1:0]      dp_s5;
	logic [L-1:0][DW+MW-1:0]     npl_s5, nph_s5;
	pgrav_pkg::tail_t            tail_s5, tail_s6, tail_s7;
	logic [DNW-1:0]              den_s6;
	logic [L-1:0][NUM_W-1:0]     num_s6;
	logic [L-1:0][QB-1:0]        qm_s7;
	logic [L-1:0][DW-1:0]        acc_out_s8;
	logic                        sing_s8, sat_s8, last_s8;

	// square root and divider outputs
	logic                        sq_vld;
	logic [RTW-1:0]              sq_root;
	logic [MID_W-1:0]            sq_sb;
	pgrav_pkg::mid_t             sq_mid;
	logic                        dv_vld;
	logic [L-1:0][QB-1:0]        dv_q;
	logic [L-1:0]                dv_ovf;
	logic [TAIL_W-1:0]           dv_sb;
	pgrav_pkg::tail_t            dv_tail;

	// whole pipeline advances unless the output beat waits
	assign en            = !vld_s8 || m_axis_tready;
	assign s_axis_tready = en;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= DW'(1) << FRAC_BITS;
			mass_q <= '0;
			src_q  <= '0;
		end else if (cfg_we) begin
			case (pgrav_pkg::cfg_idx_t'(cfg_index))
				pgrav_pkg::CFG_GRAV_CONST:  grav_q   <= cfg_data;
				pgrav_pkg::CFG_SOURCE_MASS: mass_q   <= cfg_data;
				pgrav_pkg::CFG_SOURCE_X:    src_q[0] <= cfg_data;
				pgrav_pkg::CFG_SOURCE_Y:    src_q[1] <= cfg_data;
				pgrav_pkg::CFG_SOURCE_Z:    src_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= sq_vld;
			vld_s6 <= vld_s5;
			vld_s7 <= dv_vld;
			vld_s8 <= vld_s7;
		end
	end

	// stage 1: offsets from the source and G*M
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < L; a++) begin
				d_s1[a]   <= {s_axis_tdata[DW*a+DW-1], s_axis_tdata[DW*a +: DW]}
				           - {src_q[a][DW-1], src_q[a]};
				acc_s1[a] <= s_axis_tdata[DW*(a+L) +: DW];
			end
			ena_s1  <= s_axis_tuser[0];
			last_s1 <= s_axis_tlast;
			gm_s1   <= GMW'(grav_q) * GMW'(mass_q);
		end
	end

	// stage 2: magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < L; a++) begin
				mag_s2[a] <= d_s1[a][MW-1] ? MW'(0) - d_s1[a] : d_s1[a];
				sgn_s2[a] <= d_s1[a][MW-1];
			end
			acc_s2  <= acc_s1;
			ena_s2  <= ena_s1;
			last_s2 <= last_s1;
			gm_s2   <= gm_s1;
		end
	end

	// stage 3: squares, zero-distance check
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < L; a++) begin
				sq_s3[a] <= R2W'(mag_s2[a]) * R2W'(mag_s2[a]);
			end
			sing_s3 <= (mag_s2[0] | mag_s2[1] | mag_s2[2]) == '0;
			mag_s3  <= mag_s2;
			sgn_s3  <= sgn_s2;
			acc_s3  <= acc_s2;
			ena_s3  <= ena_s2;
			last_s3 <= last_s2;
			gm_s3   <= gm_s2;
		end
	end

	// stage 4: squared distance
	always_ff @(posedge clk) begin
		if (en) begin
			r2_s4            <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			mid_s4.tail.ena  <= ena_s3;
			mid_s4.tail.last <= last_s3;
			mid_s4.tail.sing <= sing_s3;
			mid_s4.tail.sgn  <= sgn_s3;
			mid_s4.tail.acc  <= acc_s3;
			mid_s4.mag       <= mag_s3;
			mid_s4.gm        <= gm_s3;
			mid_s4.r2        <= sq_s3[0] + sq_s3[1] + sq_s3[2];
		end
	end

	pgrav_sqrt #(
		.SB_W (MID_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s4),
		.in_rad    (r2_s4),
		.in_sb     (mid_s4),
		.out_valid (sq_vld),
		.out_root  (sq_root),
		.out_sb    (sq_sb)
	);

	assign sq_mid = pgrav_pkg::mid_t'(sq_sb);

	// stage 5: partial products of r2*r and G*M*|d|
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				dp_s5[j] <= (CH+RTW)'(sq_mid.r2[CH*j +: CH]) * (CH+RTW)'(sq_root);
			end
			for (int a = 0; a < L; a++) begin
				npl_s5[a] <= (DW+MW)'(sq_mid.gm[DW-1:0]) * (DW+MW)'(sq_mid.mag[a]);
				nph_s5[a] <= (DW+MW)'(sq_mid.gm[GMW-1:DW]) * (DW+MW)'(sq_mid.mag[a]);
			end
			tail_s5 <= sq_mid.tail;
		end
	end

	// stage 6: sum partials into denominator and scaled numerators
	always_ff @(posedge clk) begin
		if (en) begin
			den_s6 <= DNW'(dp_s5[0]) + (DNW'(dp_s5[1]) << CH) + (DNW'(dp_s5[2]) << (2*CH));
			for (int a = 0; a < L; a++) begin
				num_s6[a] <= NUM_W'((PW'(nph_s5[a]) << DW) + PW'(npl_s5[a])) << FRAC_BITS;
			end
			tail_s6 <= tail_s5;
		end
	end

	pgrav_div #(
		.SB_W  (TAIL_W),
		.NUM_W (NUM_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.in_num    (num_s6),
		.in_den    (den_s6),
		.in_sb     (tail_s6),
		.out_valid (dv_vld),
		.out_q     (dv_q),
		.out_ovf   (dv_ovf),
		.out_sb    (dv_sb)
	);

	assign dv_tail = pgrav_pkg::tail_t'(dv_sb);

	// stage 7: clamp the quotient
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < L; a++) begin
				qm_s7[a] <= (dv_ovf[a] || dv_q[a] > Q_CLAMP) ? Q_CLAMP : dv_q[a];
			end
			tail_s7 <= dv_tail;
		end
	end

	// stage 8: apply the term and saturate, output register
	always_ff @(posedge clk) begin
		logic [SW-1:0] acc_w;
		logic [SW-1:0] q_w;
		logic [SW-1:0] res;
		logic          hi, lo;
		logic          sat;
		if (en) begin
			sat = 1'b0;
			for (int a = 0; a < L; a++) begin
				acc_w = {{(SW-DW){tail_s7.acc[a][DW-1]}}, tail_s7.acc[a]};
				q_w   = SW'(qm_s7[a]);
				res   = tail_s7.sgn[a] ? acc_w + q_w : acc_w - q_w;
				hi    = !res[SW-1] && res[SW-2:DW-1] != '0;
				lo    = res[SW-1] && res[SW-2:DW-1] != '1;
				if (!tail_s7.ena || tail_s7.sing) begin
					acc_out_s8[a] <= tail_s7.acc[a];
				end else if (hi) begin
					acc_out_s8[a] <= {1'b0, {(DW-1){1'b1}}};
					sat = 1'b1;
				end else if (lo) begin
					acc_out_s8[a] <= {1'b1, {(DW-1){1'b0}}};
					sat = 1'b1;
				end else begin
					acc_out_s8[a] <= res[DW-1:0];
				end
			end
			sat_s8  <= sat && tail_s7.ena && !tail_s7.sing;
			sing_s8 <= tail_s7.ena && tail_s7.sing;
			last_s8 <= tail_s7.last;
		end
	end

	assign m_axis_tvalid = vld_s8;
	assign m_axis_tdata  = acc_out_s8;
	assign m_axis_tuser  = {sat_s8, sing_s8};
	assign m_axis_tlast  = last_s8;

	// a zero-distance particle never reports clipping
	a_sing_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("singular and saturated together");

	// an output beat only appears after the clamp stage held a valid item
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s8) |-> $past(vld_s7 && en))
		else $error("output valid without an item from the clamp stage");

	// while stalled the clamp stage does not move on
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(qm_s7) && $stable(vld_s7))
		else $error("clamp stage changed during a stall");

endmodule

[design/pgrav_sqrt.sv]
// ---------------------------------------------------------------------------
// pgrav_sqrt: pipelined integer square root
// One result bit per stage by the digit-by-digit method, with a sideband
// record carried along. All stages advance together on en.
// ---------------------------------------------------------------------------
module pgrav_sqrt #(
	parameter int SB_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [pgrav_pkg::R2_W-1:0]  in_rad,
	input  logic [SB_W-1:0]             in_sb,
	output logic                        out_valid,
	output logic [pgrav_pkg::RT_W-1:0]  out_root,
	output logic [SB_W-1:0]             out_sb
);

	localparam int N  = pgrav_pkg::R2_W / 2;
	localparam int RT = pgrav_pkg::RT_W;
	localparam int RM = RT + 3;
	localparam int RW = pgrav_pkg::R2_W;

	logic          vld_s  [N];
	logic [RM-1:0] rem_s  [N];
	logic [RT-1:0] root_s [N];
	logic [RW-1:0] rad_s  [N];
	logic [SB_W-1:0] sb_s [N];

	for (genvar g = 0; g < N; g++) begin : g_step
		logic            p_vld;
		logic [RM-1:0]   p_rem;
		logic [RT-1:0]   p_root;
		logic [RW-1:0]   p_rad;
		logic [SB_W-1:0] p_sb;
		logic [RM-1:0]   rem_sh;
		logic [RM-1:0]   trial;
		logic            ge;

		if (g == 0) begin : g_first
			assign p_vld  = in_valid;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_rad  = in_rad;
			assign p_sb   = in_sb;
		end else begin : g_next
			assign p_vld  = vld_s[g-1];
			assign p_rem  = rem_s[g-1];
			assign p_root = root_s[g-1];
			assign p_rad  = rad_s[g-1];
			assign p_sb   = sb_s[g-1];
		end

		// bring down the next two radicand bits and try the next root bit
		assign rem_sh = {p_rem[RM-3:0], p_rad[RW-1 -: 2]};
		assign trial  = RM'({p_root, 2'b01});
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= ge ? rem_sh - trial : rem_sh;
				root_s[g] <= {p_root[RT-2:0], ge};
				rad_s[g]  <= {p_rad[RW-3:0], 2'b00};
				sb_s[g]   <= p_sb;
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_root  = root_s[N-1];
	assign out_sb    = sb_s[N-1];

endmodule

[design/pgrav_div.sv]
// ---------------------------------------------------------------------------
// pgrav_div: pipelined three-lane restoring divider
// Three numerators over one shared denominator, one quotient bit per stage,
// after a first stage that flags quotients too large for the result width.
// ---------------------------------------------------------------------------
module pgrav_div #(
	parameter int SB_W  = 1,
	parameter int NUM_W = 113
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               en,
	input  logic                                               in_valid,
	input  logic [pgrav_pkg::AXES-1:0][NUM_W-1:0]              in_num,
	input  logic [pgrav_pkg::DEN_W-1:0]                        in_den,
	input  logic [SB_W-1:0]                                    in_sb,
	output logic                                               out_valid,
	output logic [pgrav_pkg::AXES-1:0][pgrav_pkg::QB-1:0]      out_q,
	output logic [pgrav_pkg::AXES-1:0]                         out_ovf,
	output logic [SB_W-1:0]                                    out_sb
);

	localparam int QB = pgrav_pkg::QB;
	localparam int L  = pgrav_pkg::AXES;
	localparam int DN = pgrav_pkg::DEN_W;
	localparam int DW = DN + QB;
	localparam int N  = QB + 1;

	logic                     vld_s [N];
	logic [L-1:0][DW-1:0]     rem_s [N];
	logic [L-1:0][QB-1:0]     q_s   [N];
	logic [L-1:0]             ovf_s [N];
	logic [DN-1:0]            den_s [N];
	logic [SB_W-1:0]          sb_s  [N];

	logic [L-1:0][DW-1:0] rem_s_first;
	logic [L-1:0]         ovf_first;

	// range check: quotient would need more than QB bits
	always_comb begin
		for (int l = 0; l < L; l++) begin
			rem_s_first[l] = DW'(in_num[l]);
			ovf_first[l]   = rem_s_first[l] >= (DW'(in_den) << QB);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= rem_s_first;
			q_s[0]   <= '0;
			ovf_s[0] <= ovf_first;
			den_s[0] <= in_den;
			sb_s[0]  <= in_sb;
		end
	end

	for (genvar g = 1; g < N; g++) begin : g_bit
		logic [DW-1:0]        dsh;
		logic [L-1:0]         ge;
		logic [L-1:0][DW-1:0] rem_nx;
		logic [L-1:0][QB-1:0] q_nx;

		// trial subtract of the shifted denominator in each lane
		assign dsh = DW'(den_s[g-1]) << (QB - g);

		always_comb begin
			for (int l = 0; l < L; l++) begin
				ge[l]     = rem_s[g-1][l] >= dsh;
				rem_nx[l] = ge[l] ? rem_s[g-1][l] - dsh : rem_s[g-1][l];
				q_nx[l]   = {q_s[g-1][l][QB-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_s[g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_nx;
				q_s[g]   <= q_nx;
				ovf_s[g] <= ovf_s[g-1];
				den_s[g] <= den_s[g-1];
				sb_s[g]  <= sb_s[g-1];
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_q     = q_s[N-1];
	assign out_ovf   = ovf_s[N-1];
	assign out_sb    = sb_s[N-1];

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the point-mass acceleration unit
// Streams particles through the block under several source settings and
// idling patterns; a scoreboard predicts each result in wide integers and
// compares it field by field with the output beats.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int LATENCY  = 76;
	localparam int WD_LIMIT = 20000;

	typedef struct {
		logic signed [31:0] ax, ay, az;
		logic               singular, saturated, last;
	} grav_result_t;

	// Scoreboard: register copy, predictor and queue of pending results
	class accel_scoreboard;
		logic [31:0]  g_const, mass, src_x, src_y, src_z;
		grav_result_t pending[$];
		int           errors;

		function new();
			g_const = 32'h0001_0000;
			mass    = '0;
			src_x   = '0;
			src_y   = '0;
			src_z   = '0;
			errors  = 0;
		endfunction

		function void write_reg(pgrav_pkg::cfg_idx_t idx, logic [31:0] val);
			case (idx)
				pgrav_pkg::CFG_GRAV_CONST: begin
					g_const = val;
				end
				pgrav_pkg::CFG_SOURCE_MASS: begin
					mass = val;
				end
				pgrav_pkg::CFG_SOURCE_X: begin
					src_x = val;
				end
				pgrav_pkg::CFG_SOURCE_Y: begin
					src_y = val;
				end
				pgrav_pkg::CFG_SOURCE_Z: begin
					src_z = val;
				end
				default: begin
				end
			endcase
		endfunction

		// Integer square root, floor
		function logic [34:0] isqrt(logic [65:0] v);
			logic [34:0] root;
			logic [34:0] cand;
			root = '0;
			for (int b = 34; b >= 0; b--) begin
				cand = root | (35'd1 << b);
				if ({70'd0, v} >= 136'(cand) * 136'(cand))
					root = cand;
			end
			return root;
		endfunction

		// Apply one axis term and saturate
		function logic signed [31:0] axis_update(logic signed [31:0] acc,
				logic signed [33:0] d, logic [63:0] gm, logic [135:0] den,
				inout logic sat);
			logic [32:0]          mag;
			logic [135:0]         num, q;
			logic [33:0]          qm;
			logic signed [35:0]   r;
			mag = d < 0 ? 33'(-d) : 33'(d);
			num = (136'(gm) * 136'(mag)) << 16;
			num = num & {8'd0, {128{1'b1}}};
			q   = num / den;
			qm  = (q > 136'(34'h2_0000_0000)) ? 34'h2_0000_0000 : q[33:0];
			r   = 36'(acc);
			if (d > 0)
				r = r - 36'(qm);
			else if (d < 0)
				r = r + 36'(qm);
			if (r > 36'sd2147483647) begin
				r = 36'sd2147483647;
				sat = 1'b1;
			end
			if (r < -36'sd2147483648) begin
				r = -36'sd2147483648;
				sat = 1'b1;
			end
			return r[31:0];
		endfunction

		function void note_particle(logic [191:0] data, logic ena, logic last);
			grav_result_t       res;
			logic signed [33:0] dx, dy, dz;
			logic [65:0]        r2;
			logic [34:0]        root;
			logic [135:0]       den;
			logic [63:0]        gm;
			res.ax        = data[127:96];
			res.ay        = data[159:128];
			res.az        = data[191:160];
			res.singular  = 1'b0;
			res.saturated = 1'b0;
			res.last      = last;
			if (ena) begin
				dx = 34'(signed'(data[31:0]))  - 34'(signed'(src_x));
				dy = 34'(signed'(data[63:32])) - 34'(signed'(src_y));
				dz = 34'(signed'(data[95:64])) - 34'(signed'(src_z));
				r2 = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy) + 66'(dz) * 66'(dz);
				if (r2 == 0) begin
					res.singular = 1'b1;
				end else begin
					root = isqrt(r2);
					den  = 136'(r2) * 136'(root);
					gm   = 64'(g_const) * 64'(mass);
					res.ax = axis_update(res.ax, dx, gm, den, res.saturated);
					res.ay = axis_update(res.ay, dy, gm, den, res.saturated);
					res.az = axis_update(res.az, dz, gm, den, res.saturated);
				end
			end
			pending.push_back(res);
		endfunction

		function void check_beat(logic [95:0] data, logic [1:0] user, logic last);
			grav_result_t want;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (data[31:0] !== want.ax) begin
				$error("acc_out_x: expected %h, got %h", want.ax, data[31:0]);
				errors++;
			end
			if (data[63:32] !== want.ay) begin
				$error("acc_out_y: expected %h, got %h", want.ay, data[63:32]);
				errors++;
			end
			if (data[95:64] !== want.az) begin
				$error("acc_out_z: expected %h, got %h", want.az, data[95:64]);
				errors++;
			end
			if (user[0] !== want.singular) begin
				$error("singular: expected %b, got %b", want.singular, user[0]);
				errors++;
			end
			if (user[1] !== want.saturated) begin
				$error("saturated: expected %b, got %b", want.saturated, user[1]);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_out: expected %b, got %b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;
	logic         s_axis_tvalid, s_axis_tready;
	logic [191:0] s_axis_tdata;
	logic [0:0]   s_axis_tuser;
	logic         s_axis_tlast;
	logic         m_axis_tvalid, m_axis_tready;
	logic [95:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;

	accel_scoreboard sb = new();
	int  send_idle_pct, recv_stall_pct;
	bit  hold_off;
	int  idle_cycles;

	always #5 clk = ~clk;

	point_mass_gravity_accel_unit i_dut (.*);

	// Check result beats and count quiet cycles
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver readiness
	always @(posedge clk) begin
		m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		if (idle_cycles >= WD_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_cfg(pgrav_pkg::cfg_idx_t idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	// Offer one particle, with random gaps ahead of it
	task automatic send_particle(logic [31:0] px, py, pz, ax, ay, az, logic ena,
			logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {az, ay, ax, pz, py, px};
		s_axis_tuser  <= ena;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_particle({az, ay, ax, pz, py, px}, ena, last);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			3: return $urandom;
			default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
		endcase
	endfunction

	// Random particles, mostly enabled and near the source
	task automatic random_batch(int n);
		logic [31:0] p[3];
		for (int i = 0; i < n; i++) begin
			for (int a = 0; a < 3; a++) begin
				case ($urandom_range(7))
					0: p[a] = rand_word();
					1: p[a] = (a == 0) ? sb.src_x : (a == 1) ? sb.src_y : sb.src_z;
					default: p[a] = ((a == 0) ? sb.src_x : (a == 1) ? sb.src_y : sb.src_z)
						+ ($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
				endcase
			end
			send_particle(p[0], p[1], p[2], rand_word(), rand_word(), rand_word(),
				$urandom_range(9) != 0, $urandom_range(7) == 0);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		hold_off      = 1'b0;
		idle_cycles   = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset defaults (zero mass) then unit source
		send_particle(32'h0001_0000, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 5, 1, 0);
		send_particle(0, 0, 0, 1, 2, 3, 1, 1);
		drain();
		write_cfg(pgrav_pkg::CFG_SOURCE_MASS, 32'h0001_0000);
		send_particle(0, 0, 0, 1, 2, 3, 1, 0);
		send_particle(0, 0, 0, 1, 2, 3, 0, 1);
		send_particle(32'h0001_0000, 0, 0, 0, 0, 0, 1, 0);
		send_particle(0, 32'hffff_0000, 0, 0, 0, 0, 1, 0);
		send_particle(0, 0, 32'h0000_0001, 0, 0, 0, 1, 0);
		send_particle(1, 1, 1, 32'h8000_0000, 32'h7fff_ffff, 0, 1, 0);
		send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 1, 0);
		send_particle(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 1, 1);
		send_particle(32'hffff_ffff, 0, 0, 32'hffff_ffff, 0, 0, 1, 0);
		send_particle(32'h0000_0100, 32'h0000_0100, 0, 0, 0, 0, 0, 0);
		drain();

		// Extreme settings
		write_cfg(pgrav_pkg::CFG_GRAV_CONST, 32'hffff_ffff);
		write_cfg(pgrav_pkg::CFG_SOURCE_MASS, 32'hffff_ffff);
		write_cfg(pgrav_pkg::CFG_SOURCE_X, 32'h7fff_ffff);
		write_cfg(pgrav_pkg::CFG_SOURCE_Y, 32'h8000_0000);
		write_cfg(pgrav_pkg::CFG_SOURCE_Z, 32'h0);
		send_particle(32'h8000_0000, 32'h7fff_ffff, 1, 0, 0, 0, 1, 0);
		send_particle(32'h7fff_ffff, 32'h8000_0000, 0, 7, 7, 7, 1, 1);
		send_particle(32'h7fff_fffe, 32'h8000_0001, 0, 0, 0, 0, 1, 0);
		random_batch(20);
		drain();
		write_cfg(pgrav_pkg::CFG_GRAV_CONST, 32'h0);
		random_batch(20);
		drain();

		// Random phases under different settings and idling
		for (int ph = 0; ph < 4; ph++) begin
			write_cfg(pgrav_pkg::CFG_GRAV_CONST,
				ph == 3 ? 32'h0001_0000 : $urandom_range(32'h0010_0000));
			write_cfg(pgrav_pkg::CFG_SOURCE_MASS,
				ph == 2 ? 32'hffff_ffff : $urandom_range(32'h0100_0000));
			write_cfg(pgrav_pkg::CFG_SOURCE_X, rand_word());
			write_cfg(pgrav_pkg::CFG_SOURCE_Y, rand_word());
			write_cfg(pgrav_pkg::CFG_SOURCE_Z, rand_word());
			send_idle_pct  = (ph == 1 || ph == 3) ? 77 : 0;
			recv_stall_pct = (ph == 1) ? 0 : (ph == 0 ? 0 : (ph == 2 ? 77 : 14));
			if (ph == 3) begin
				send_idle_pct  = 14;
			end
			if (ph == 0) begin
				// Long receiver hold-off while the sender keeps offering
				fork
					begin
						hold_off = 1'b1;
						repeat (300) @(posedge clk);
						hold_off = 1'b0;
					end
					random_batch(220);
				join
			end else begin
				random_batch(220);
			end
			drain();
		end

		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
